### design/sshdf_pkg.sv
// Shared types, constants and the CRC byte update for the SSH-1 packet deframer.
package sshdf_pkg;

   localparam int LENGTH_BITS = 19;
   localparam logic [7:0] DEBUG_TYPE = 8'd36;
   localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [31:0] MIN_LENGTH = 32'd5;
   localparam logic [LENGTH_BITS-1:0] HEADER_BYTES = LENGTH_BITS'(5);

   localparam logic [31:0] CRC_POLY_RESET = 32'hEDB8_8320;
   localparam logic [18:0] MAX_LENGTH_RESET = 19'(262144 + 8);

   localparam logic CSR_CRC_POLY = 1'b0;
   localparam logic CSR_MAX_LENGTH = 1'b1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      KIND_TYPE = 2'd0,
      KIND_DATA = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BAD_CRC = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_TOO_SMALL = 3'd3,
      ST_ILLEGAL_TYPE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_PAD = 3'd0,
      OP_TYPE = 3'd1,
      OP_DATA = 3'd2,
      OP_CRC = 3'd3,
      OP_LEN_ERR = 3'd4
   } op_code_type;

   // one classified request handed from the parser to the back end
   typedef struct packed {
      op_code_type code;
      logic [7:0] data;
      logic crc_last;
      status_type status;
   } op_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                            input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ poly;
         else c = c >> 1;
      end
      return c;
   endfunction

endpackage

### design/sshdf_fifo.sv
// Small queue between the parser front end and the CRC back end.
module sshdf_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  sshdf_pkg::op_type push_op,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output sshdf_pkg::op_type pop_op
);

   sshdf_pkg::op_type mem_ff [sshdf_pkg::FIFO_DEPTH];
   logic [sshdf_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sshdf_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sshdf_pkg::FIFO_AW:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == (sshdf_pkg::FIFO_AW+1)'(sshdf_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_op = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/sshdf_front.sv
// Front end: tracks the packet framing and classifies each received byte.
module sshdf_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic [18:0] max_length,
   input  logic fifo_full,
   output logic push,
   output sshdf_pkg::op_type push_op
);

   typedef enum logic [5:0] {
      PH_LEN = 6'b000001,
      PH_PAD = 6'b000010,
      PH_TYPE = 6'b000100,
      PH_DATA = 6'b001000,
      PH_CRC = 6'b010000,
      PH_HALT = 6'b100000
   } phase_type;

   localparam int LB = sshdf_pkg::LENGTH_BITS;

   phase_type phase_ff, phase_in;
   logic [LB-1:0] count_ff, count_in;
   logic [LB-1:0] wire_len_ff, wire_len_in;
   logic [LB-1:0] data_len_ff, data_len_in;
   logic [23:0] shift_ff, shift_in;
   logic [31:0] full_len;
   logic [LB-1:0] count_next;
   logic [3:0] pad_len;
   logic take;

   assign req_ready = !fifo_full;
   assign take = req_valid && req_ready;
   assign full_len = {shift_ff, req_rx_byte};
   assign count_next = count_ff + 1'b1;
   assign pad_len = 4'd8 - {1'b0, wire_len_ff[2:0]};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      wire_len_in = wire_len_ff;
      data_len_in = data_len_ff;
      shift_in = shift_ff;
      push = 1'b0;
      push_op.code = sshdf_pkg::OP_PAD;
      push_op.data = req_rx_byte;
      push_op.crc_last = 1'b0;
      push_op.status = sshdf_pkg::ST_OK;
      if (take) begin
         case (phase_ff)
            PH_LEN: begin
               if (count_ff < LB'(3)) begin
                  shift_in = {shift_ff[15:0], req_rx_byte};
                  count_in = count_next;
               end else if (full_len > {13'd0, max_length} ||
                            full_len > sshdf_pkg::LEN_LIMIT) begin
                  push = 1'b1;
                  push_op.code = sshdf_pkg::OP_LEN_ERR;
                  push_op.status = sshdf_pkg::ST_TOO_LARGE;
                  phase_in = PH_HALT;
               end else if (full_len < sshdf_pkg::MIN_LENGTH) begin
                  push = 1'b1;
                  push_op.code = sshdf_pkg::OP_LEN_ERR;
                  push_op.status = sshdf_pkg::ST_TOO_SMALL;
                  phase_in = PH_HALT;
               end else begin
                  wire_len_in = full_len[LB-1:0];
                  data_len_in = full_len[LB-1:0] - sshdf_pkg::HEADER_BYTES;
                  count_in = '0;
                  phase_in = PH_PAD;
               end
            end
            PH_PAD: begin
               push = 1'b1;
               push_op.code = sshdf_pkg::OP_PAD;
               if (count_next >= {{(LB-4){1'b0}}, pad_len}) begin
                  count_in = '0;
                  phase_in = PH_TYPE;
               end else begin
                  count_in = count_next;
               end
            end
            PH_TYPE: begin
               push = 1'b1;
               push_op.code = sshdf_pkg::OP_TYPE;
               count_in = '0;
               phase_in = (wire_len_ff > sshdf_pkg::HEADER_BYTES) ? PH_DATA : PH_CRC;
            end
            PH_DATA: begin
               push = 1'b1;
               push_op.code = sshdf_pkg::OP_DATA;
               if (count_next >= data_len_ff) begin
                  count_in = '0;
                  phase_in = PH_CRC;
               end else begin
                  count_in = count_next;
               end
            end
            PH_CRC: begin
               push = 1'b1;
               push_op.code = sshdf_pkg::OP_CRC;
               if (count_ff == LB'(3)) begin
                  push_op.crc_last = 1'b1;
                  count_in = '0;
                  shift_in = '0;
                  phase_in = PH_LEN;
               end else begin
                  count_in = count_next;
               end
            end
            PH_HALT: begin
               // dead until reset
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         count_ff <= '0;
         shift_ff <= '0;
         wire_len_ff <= '0;
         data_len_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         wire_len_ff <= wire_len_in;
         data_len_ff <= data_len_in;
      end
   end

endmodule

### design/sshdf_back.sv
// Back end: runs the CRC, checks it and drives the registered result channel.
module sshdf_back (
   input  logic clock,
   input  logic reset,
   input  logic [31:0] crc_poly,
   input  logic op_valid,
   input  sshdf_pkg::op_type op,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic rsp_last
);

   logic [31:0] crc_ff, crc_in;
   logic [23:0] recv_ff, recv_in;
   logic [7:0] type_ff, type_in;
   logic valid_ff, valid_in;
   sshdf_pkg::kind_type kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   sshdf_pkg::status_type status_ff, status_in;
   logic last_ff, last_in;
   logic [31:0] crc_upd;
   logic [31:0] recv_full;
   logic emit;

   assign pop = op_valid && (!valid_ff || rsp_ready);
   assign crc_upd = sshdf_pkg::crc_byte(crc_ff, op.data, crc_poly);
   assign recv_full = {recv_ff, op.data};

   always_comb begin
      crc_in = crc_ff;
      recv_in = recv_ff;
      type_in = type_ff;
      emit = 1'b0;
      kind_in = kind_ff;
      byte_in = 8'd0;
      status_in = sshdf_pkg::ST_OK;
      last_in = 1'b0;
      if (pop) begin
         case (op.code)
            sshdf_pkg::OP_PAD: begin
               crc_in = crc_upd;
            end
            sshdf_pkg::OP_TYPE: begin
               crc_in = crc_upd;
               type_in = op.data;
               if (op.data != sshdf_pkg::DEBUG_TYPE) begin
                  emit = 1'b1;
                  kind_in = sshdf_pkg::KIND_TYPE;
                  byte_in = op.data;
               end
            end
            sshdf_pkg::OP_DATA: begin
               crc_in = crc_upd;
               if (type_ff != sshdf_pkg::DEBUG_TYPE) begin
                  emit = 1'b1;
                  kind_in = sshdf_pkg::KIND_DATA;
                  byte_in = op.data;
               end
            end
            sshdf_pkg::OP_CRC: begin
               recv_in = recv_full[23:0];
               if (op.crc_last) begin
                  crc_in = '0;
                  recv_in = '0;
                  type_in = '0;
                  kind_in = sshdf_pkg::KIND_STATUS;
                  last_in = 1'b1;
                  // a bad CRC wins over debug and over type zero
                  if (recv_full != crc_ff) begin
                     emit = 1'b1;
                     status_in = sshdf_pkg::ST_BAD_CRC;
                  end else if (type_ff == 8'd0) begin
                     emit = 1'b1;
                     status_in = sshdf_pkg::ST_ILLEGAL_TYPE;
                  end else if (type_ff != sshdf_pkg::DEBUG_TYPE) begin
                     emit = 1'b1;
                  end
               end
            end
            sshdf_pkg::OP_LEN_ERR: begin
               emit = 1'b1;
               kind_in = sshdf_pkg::KIND_STATUS;
               status_in = op.status;
               last_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
      valid_in = emit ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
         recv_ff <= '0;
         type_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         recv_ff <= recv_in;
         type_ff <= type_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         status_ff <= status_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status = status_ff;
   assign rsp_last = last_ff;

endmodule

### design/ssh1_packet_deframer_crc_check_top.sv
// SSH-1 packet deframer with CRC-32 check: top level.
// Throughput: one received byte per cycle, sustained while results are taken.
// A byte's result passes through the queue and then the output register before it is valid.
// A four-entry queue between parser and CRC unit absorbs result-side stalls.
// Synchronous active-high reset returns to awaiting the length and restores
// the CRC polynomial and maximum length registers to their defaults.
module ssh1_packet_deframer_crc_check_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic rsp_last,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] crc_poly_ff;
   logic [18:0] max_length_ff;
   logic fifo_full, fifo_not_empty, push, pop;
   sshdf_pkg::op_type push_op, pop_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff <= sshdf_pkg::CRC_POLY_RESET;
         max_length_ff <= sshdf_pkg::MAX_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sshdf_pkg::CSR_CRC_POLY: crc_poly_ff <= csr_wdata;
            sshdf_pkg::CSR_MAX_LENGTH: max_length_ff <= csr_wdata[18:0];
            default: begin
            end
         endcase
      end
   end

   sshdf_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .max_length(max_length_ff),
      .fifo_full(fifo_full),
      .push(push),
      .push_op(push_op)
   );

   sshdf_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_op(push_op),
      .full(fifo_full),
      .pop(pop),
      .not_empty(fifo_not_empty),
      .pop_op(pop_op)
   );

   sshdf_back u_back (
      .clock(clock),
      .reset(reset),
      .crc_poly(crc_poly_ff),
      .op_valid(fifo_not_empty),
      .op(pop_op),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

endmodule

### dv/tb_top.sv
// Testbench for the SSH-1 packet deframer: framed byte traffic checked against a predictor.
module tb_top;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [2:0] {
      FR_LEN,
      FR_PAD,
      FR_TYPE,
      FR_BODY,
      FR_CRC,
      FR_HALT
   } frame_phase_type;

   typedef struct packed {
      sshdf_pkg::kind_type kind;
      logic [7:0] data;
      sshdf_pkg::status_type status;
      logic last;
   } deframe_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_status;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic csr_index = sshdf_pkg::CSR_CRC_POLY;
   logic [31:0] csr_wdata = 32'd0;

   ssh1_packet_deframer_crc_check_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor state and its copy of the registers
   frame_phase_type fr_phase;
   logic [18:0] fr_count;
   logic [18:0] fr_len;
   logic [31:0] fr_crc;
   logic [31:0] fr_rx_crc;
   logic [7:0] fr_type;
   logic [23:0] fr_hdr;
   logic [31:0] cfg_poly = sshdf_pkg::CRC_POLY_RESET;
   logic [18:0] cfg_max_len = sshdf_pkg::MAX_LENGTH_RESET;

   deframe_result_type pending_outputs[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int byte_total = 0;
   int rx_mode = 0;
   int rx_tick = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] crc_advance(input logic [31:0] crc, input logic [7:0] b,
                                               input logic [31:0] poly);
      logic [31:0] r;
      r = crc ^ 32'(b);
      repeat (8) r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
      return r;
   endfunction

   function automatic void restart_frame();
      fr_phase = FR_LEN;
      fr_count = '0;
      fr_len = '0;
      fr_crc = '0;
      fr_rx_crc = '0;
      fr_type = '0;
      fr_hdr = '0;
   endfunction

   function automatic void push_result(input sshdf_pkg::kind_type k, input logic [7:0] d,
                                       input sshdf_pkg::status_type s);
      pending_outputs.push_back('{kind: k, data: d, status: s,
                                  last: (k == sshdf_pkg::KIND_STATUS)});
   endfunction

   function automatic void advance_deframer(input logic [7:0] b);
      logic [31:0] full;
      logic is_debug;
      logic [31:0] rx;
      logic [31:0] calc;
      logic [7:0] ty;
      is_debug = (fr_type == sshdf_pkg::DEBUG_TYPE);
      case (fr_phase)
         FR_LEN: begin
            if (fr_count < 3) begin
               fr_hdr = {fr_hdr[15:0], b};
               fr_count++;
            end else begin
               full = {fr_hdr, b};
               // too large is checked ahead of too small
               if (full > {13'd0, cfg_max_len} || full > sshdf_pkg::LEN_LIMIT) begin
                  fr_phase = FR_HALT;
                  push_result(sshdf_pkg::KIND_STATUS, 8'd0, sshdf_pkg::ST_TOO_LARGE);
               end else if (full < sshdf_pkg::MIN_LENGTH) begin
                  fr_phase = FR_HALT;
                  push_result(sshdf_pkg::KIND_STATUS, 8'd0, sshdf_pkg::ST_TOO_SMALL);
               end else begin
                  fr_len = full[18:0];
                  fr_count = '0;
                  fr_phase = FR_PAD;
               end
            end
         end
         FR_PAD: begin
            fr_crc = crc_advance(fr_crc, b, cfg_poly);
            fr_count++;
            if (fr_count >= 8 - fr_len[2:0]) begin
               fr_count = '0;
               fr_phase = FR_TYPE;
            end
         end
         FR_TYPE: begin
            fr_crc = crc_advance(fr_crc, b, cfg_poly);
            fr_type = b;
            fr_count = '0;
            fr_phase = (fr_len > 19'd5) ? FR_BODY : FR_CRC;
            if (b != sshdf_pkg::DEBUG_TYPE)
               push_result(sshdf_pkg::KIND_TYPE, b, sshdf_pkg::ST_OK);
         end
         FR_BODY: begin
            fr_crc = crc_advance(fr_crc, b, cfg_poly);
            fr_count++;
            if (fr_count >= fr_len - 19'd5) begin
               fr_count = '0;
               fr_phase = FR_CRC;
            end
            if (!is_debug) push_result(sshdf_pkg::KIND_DATA, b, sshdf_pkg::ST_OK);
         end
         FR_CRC: begin
            fr_rx_crc = {fr_rx_crc[23:0], b};
            fr_count++;
            if (fr_count == 4) begin
               rx = fr_rx_crc;
               calc = fr_crc;
               ty = fr_type;
               restart_frame();
               // a bad CRC outranks both debug silence and type zero
               if (rx != calc)
                  push_result(sshdf_pkg::KIND_STATUS, 8'd0, sshdf_pkg::ST_BAD_CRC);
               else if (ty == sshdf_pkg::DEBUG_TYPE) ;
               else if (ty == 8'd0)
                  push_result(sshdf_pkg::KIND_STATUS, 8'd0, sshdf_pkg::ST_ILLEGAL_TYPE);
               else push_result(sshdf_pkg::KIND_STATUS, 8'd0, sshdf_pkg::ST_OK);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      byte_total++;
      advance_deframer(b);
   endtask

   task automatic send_length(input logic [31:0] len);
      int i;
      for (i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
   endtask

   // fill < 0 means random pad and payload bytes
   task automatic send_packet(input int len, input logic [7:0] ptype, input bit corrupt,
                              input int fill);
      logic [7:0] body[$];
      logic [31:0] crc;
      int pad;
      int i;
      crc = '0;
      pad = 8 - (len % 8);
      for (i = 0; i < pad; i++) body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      body.push_back(ptype);
      for (i = 0; i < len - 5; i++) body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      foreach (body[j]) crc = crc_advance(crc, body[j], cfg_poly);
      if (corrupt) crc ^= 32'd1 << $urandom_range(0, 31);
      send_length(32'(len));
      foreach (body[j]) send_byte(body[j]);
      for (i = 3; i >= 0; i--) send_byte(crc[8*i +: 8]);
   endtask

   function automatic int pick_length();
      int cap;
      cap = (cfg_max_len < 48) ? int'(cfg_max_len) : 48;
      case ($urandom_range(0, 19))
         0: return (cfg_max_len <= 400) ? int'(cfg_max_len) : $urandom_range(5, 400);
         1: return $urandom_range(5, (cfg_max_len < 400) ? int'(cfg_max_len) : 400);
         default: return $urandom_range(5, cap);
      endcase
   endfunction

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return sshdf_pkg::DEBUG_TYPE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_packets(input int n_bytes);
      int target;
      target = byte_total + n_bytes;
      while (byte_total < target)
         send_packet(pick_length(), pick_type(), $urandom_range(0, 7) == 0, -1);
   endtask

   // only written once the block has drained
   task automatic write_reg(input logic idx, input logic [31:0] data);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sshdf_pkg::CSR_CRC_POLY) cfg_poly = data;
      else cfg_max_len = data[18:0];
   endtask

   // junk above bit 18 must be dropped by the block
   task automatic set_config(input logic [31:0] poly, input logic [18:0] max_len);
      write_reg(sshdf_pkg::CSR_CRC_POLY, poly);
      write_reg(sshdf_pkg::CSR_MAX_LENGTH, {13'($urandom), max_len});
   endtask

   task automatic test_short_packets();
      send_packet(8, 8'h00, 1'b0, 8'hFF);
      send_packet(5, sshdf_pkg::DEBUG_TYPE, 1'b1, 8'h00);
      send_packet(6, sshdf_pkg::DEBUG_TYPE, 1'b0, -1);
   endtask

   task automatic test_default_traffic();
      random_packets(450);
   endtask

   task automatic test_register_settings();
      set_config(32'd0, 19'd5);
      random_packets(80);
      set_config(32'hFFFF_FFFF, 19'h7FFFF);
      random_packets(150);
      set_config($urandom, 19'($urandom_range(5, 60)));
      random_packets(150);
      set_config($urandom, 19'($urandom_range(5, 524287)));
      random_packets(150);
      set_config(sshdf_pkg::CRC_POLY_RESET, sshdf_pkg::MAX_LENGTH_RESET);
      random_packets(100);
   endtask

   // the block halts for good here, so this runs last
   task automatic test_length_error();
      logic [31:0] len;
      int i;
      case ($urandom_range(0, 2))
         0: len = $urandom_range(0, 4);
         1: begin
            set_config(cfg_poly, 19'($urandom_range(5, 2000)));
            len = ($urandom_range(0, 1) == 0) ? 32'(cfg_max_len) + 32'd1
                                               : $urandom_range(cfg_max_len + 1, 524287);
         end
         default: begin
            set_config(cfg_poly, 19'h7FFFF);
            len = $urandom | (32'h8_0000 << $urandom_range(0, 12));
         end
      endcase
      send_length(len);
      for (i = 0; i < 16; i++) send_byte(8'($urandom));
   endtask

   initial begin
      restart_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_short_packets();
      test_default_traffic();
      test_register_settings();
      test_length_error();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   // receiver: switches between stall patterns every so often
   always @(posedge clock) begin
      if (rx_tick == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_tick <= $urandom_range(20, 120);
      end else begin
         rx_tick <= rx_tick - 1;
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= (rx_tick[2:0] < 3'd3);
      endcase
   end

   always @(posedge clock) begin : check_results
      deframe_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected result: kind %0d byte %0h status %0d last %0d",
                   rsp_kind, rsp_out_byte, rsp_status, rsp_last);
            mismatch_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
